// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same check with the project clock and reset names
`define ASSERT_DEF(label, prop) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// nns_pkg
// shared types and constants of the nearest neighbor image scaler
// ----------------------------------------------------------------------------
package nns_pkg;

  // fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REPL_W    = 4;
  // copy counts, wide enough for the largest copy limit
  localparam int unsigned CNT_W     = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // input modes
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_REPLAY = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // one expanded output pixel run
  typedef struct packed {
    logic              use_mem;
    pixel_t            pix;
    logic [CNT_W-1:0]  copies;
    logic              last_col;
    logic [REPL_W-1:0] replays;
    logic              last_pix;
  } job_t;

endpackage

// ===== hw/rtl/nns_line_buf.sv =====
// ----------------------------------------------------------------------------
// nns_line_buf
// one-row pixel store, one write and one registered read port
// ----------------------------------------------------------------------------
module nns_line_buf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  nns_pkg::pixel_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output nns_pkg::pixel_t rd_data_o
);
  import nns_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/nns_ctrl.sv =====
// ----------------------------------------------------------------------------
// nns_ctrl
// configuration registers, image position and per-request copy counts
// ----------------------------------------------------------------------------
module nns_ctrl #(
  parameter int unsigned MAX_WIDTH       = 2048,
  parameter int unsigned MAX_HEIGHT      = 2048,
  parameter int unsigned SCALE_FRAC_BITS = 8,
  parameter int unsigned MAX_COPIES      = 16,
  parameter int unsigned AW              = 11
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [nns_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [nns_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 accept_i,
  input  logic                                 mode_i,
  input  nns_pkg::pixel_t                      pix_i,
  output logic                                 job_valid_o,
  output nns_pkg::job_t                        job_o,
  output logic                                 wr_en_o,
  output logic [AW-1:0]                        wr_addr_o,
  output logic [AW-1:0]                        rd_addr_o
);
  import nns_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW = ((CW > RW) ? CW : RW) > CFG_W ? ((CW > RW) ? CW : RW) : CFG_W;
  localparam int unsigned PW = ((CW > RW) ? CW : RW) + CFG_W + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (SCALE_FRAC_BITS - 1);

  // configuration
  logic [CFG_W-1:0] scale_q, width_q, height_q;
  // position state
  logic [CW-1:0]    src_col_q, src_col_d;
  logic [PW-1:0]    col_prod_q, col_prod_d;
  logic [RW-1:0]    src_row_q, src_row_d;
  logic [PW-1:0]    row_prod_q, row_prod_d;
  logic [CW-1:0]    rep_col_q, rep_col_d;
  logic [PW-1:0]    rep_prod_q, rep_prod_d;
  logic [CNT_W-1:0] rtr_q, rtr_d;

  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [CW-1:0]    col_c;
  logic [PW-1:0]    col_p;
  logic [RW-1:0]    row_c;
  logic [PW-1:0]    row_p;
  logic [CNT_W-1:0] rows, copies, rep_copies;
  logic             last_c, last_r;

  // distance between rounded edges at base and base plus one step
  function automatic logic [CNT_W-1:0] span_f(input logic [PW-1:0] base,
                                              input logic [CFG_W-1:0] sf);
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [PW-1:0] diff;
    lo   = (base + HALF) >> SCALE_FRAC_BITS;
    hi   = (base + PW'(sf) + HALF) >> SCALE_FRAC_BITS;
    diff = hi - lo;
    return (diff > PW'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : diff[CNT_W-1:0];
  endfunction

  // effective dimensions, zero counts as one, saturate at the limits
  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (XW'(height_q) > XW'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // position after the new image and new row wraps
  always_comb begin
    row_c = src_row_q;
    row_p = row_prod_q;
    col_c = src_col_q;
    col_p = col_prod_q;
    if (src_row_q >= h_eff) begin
      row_c = '0;
      row_p = '0;
      col_c = '0;
      col_p = '0;
    end
    if (col_c >= w_eff) begin
      col_c = '0;
      col_p = '0;
    end
  end

  assign rows       = span_f(row_p, scale_q);
  assign copies     = span_f(col_p, scale_q);
  assign rep_copies = span_f(rep_prod_q, scale_q);
  assign last_c     = (col_c == w_eff - CW'(1));
  assign last_r     = (rep_col_q == w_eff - CW'(1));

  // next state and job for the accepted request
  always_comb begin
    src_col_d   = src_col_q;
    col_prod_d  = col_prod_q;
    src_row_d   = src_row_q;
    row_prod_d  = row_prod_q;
    rep_col_d   = rep_col_q;
    rep_prod_d  = rep_prod_q;
    rtr_d       = rtr_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    job_o.pix   = pix_i;
    wr_en_o     = 1'b0;
    wr_addr_o   = col_c[AW-1:0];
    rd_addr_o   = rep_col_q[AW-1:0];
    if (accept_i && mode_i == MODE_PIXEL) begin
      wr_en_o         = 1'b1;
      job_valid_o     = (rows != '0) && (copies != '0);
      job_o.use_mem   = 1'b0;
      job_o.copies    = copies;
      job_o.last_col  = last_c;
      job_o.replays   = REPL_W'(rows - CNT_W'(1));
      job_o.last_pix  = last_c && (row_c == h_eff - RW'(1)) && (rows == CNT_W'(1));
      rtr_d           = '0;
      rep_col_d       = '0;
      rep_prod_d      = '0;
      if (last_c) begin
        rtr_d      = (rows != '0) ? rows - CNT_W'(1) : '0;
        src_col_d  = '0;
        col_prod_d = '0;
        src_row_d  = row_c + RW'(1);
        row_prod_d = row_p + PW'(scale_q);
      end else begin
        src_col_d  = col_c + CW'(1);
        col_prod_d = col_p + PW'(scale_q);
        src_row_d  = row_c;
        row_prod_d = row_p;
      end
    end else if (accept_i && rtr_q != '0) begin
      if (rep_col_q >= w_eff) begin
        rep_col_d  = '0;
        rep_prod_d = '0;
        rtr_d      = '0;
      end else begin
        job_valid_o    = (rep_copies != '0);
        job_o.use_mem  = 1'b1;
        job_o.copies   = rep_copies;
        job_o.last_col = last_r;
        job_o.replays  = REPL_W'(rtr_q - CNT_W'(1));
        job_o.last_pix = last_r && (rtr_q == CNT_W'(1)) && (src_row_q >= h_eff);
        if (last_r) begin
          rtr_d      = rtr_q - CNT_W'(1);
          rep_col_d  = '0;
          rep_prod_d = '0;
        end else begin
          rep_col_d  = rep_col_q + CW'(1);
          rep_prod_d = rep_prod_q + PW'(scale_q);
        end
      end
    end
  end

  // state registers, a configuration write restarts the image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= CFG_W'(256);
      width_q    <= CFG_W'(1);
      height_q   <= CFG_W'(1);
      src_col_q  <= '0;
      col_prod_q <= '0;
      src_row_q  <= '0;
      row_prod_q <= '0;
      rep_col_q  <= '0;
      rep_prod_q <= '0;
      rtr_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCALE:  scale_q  <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i == CFG_SCALE || cfg_index_i == CFG_WIDTH ||
          cfg_index_i == CFG_HEIGHT) begin
        src_col_q  <= '0;
        col_prod_q <= '0;
        src_row_q  <= '0;
        row_prod_q <= '0;
        rep_col_q  <= '0;
        rep_prod_q <= '0;
        rtr_q      <= '0;
      end
    end else begin
      src_col_q  <= src_col_d;
      col_prod_q <= col_prod_d;
      src_row_q  <= src_row_d;
      row_prod_q <= row_prod_d;
      rep_col_q  <= rep_col_d;
      rep_prod_q <= rep_prod_d;
      rtr_q      <= rtr_d;
    end
  end

endmodule

// ===== hw/rtl/nns_emit.sv =====
// ----------------------------------------------------------------------------
// nns_emit
// job stage aligned with the buffer read, then the copy emitter
// ----------------------------------------------------------------------------
module nns_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  nns_pkg::job_t                  job_i,
  input  nns_pkg::pixel_t                rd_data_i,
  output logic                           stall_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nns_pkg::pixel_t                pix_o,
  output logic                           end_of_row_o,
  output logic [nns_pkg::REPL_W-1:0]     replays_left_o,
  output logic                           end_of_image_o
);
  import nns_pkg::*;

  logic              b_valid_q;
  job_t              b_job_q;
  pixel_t            b_pix;
  logic              load;
  logic [CNT_W-1:0]  cnt_q;
  pixel_t            pix_q;
  logic              last_col_q;
  logic              last_pix_q;
  logic [REPL_W-1:0] replays_q;

  // replayed pixels come from the buffer read issued with the job
  assign b_pix = b_job_q.use_mem ? rd_data_i : b_job_q.pix;

  // take the next job when idle or when the last copy leaves
  assign load    = b_valid_q && ((cnt_q == '0) ||
                   (cnt_q == CNT_W'(1) && !out_stall_i));
  assign stall_o = b_valid_q && !load;

  // job stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || load) begin
      b_valid_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && (!b_valid_q || load)) begin
      b_job_q <= job_i;
    end
  end

  // copy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= b_job_q.copies;
    end else if (cnt_q != '0 && !out_stall_i) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q      <= b_pix;
      last_col_q <= b_job_q.last_col;
      last_pix_q <= b_job_q.last_pix;
      replays_q  <= b_job_q.replays;
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign pix_o          = pix_q;
  assign end_of_row_o   = last_col_q && (cnt_q == CNT_W'(1));
  assign end_of_image_o = last_pix_q && (cnt_q == CNT_W'(1));
  assign replays_left_o = replays_q;

endmodule

// ===== hw/rtl/nearest_neighbor_image_scaler_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// nearest neighbor scaler for 24-bit bgr pixels with a one-row buffer
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries mode and a bgr pixel;
//   mode 0 stores a source pixel and emits its copies for the first output
//   row, mode 1 replays the next buffered pixel for a repeated output row.
//   output channel (out_valid_o / out_stall_i) carries the copies of each
//   request with end-of-row, replays-left and end-of-image flags.
//   configuration port (cfg_valid_i / cfg_ready_o) is always ready; index 0
//   scale factor (q4.8), 1 source width, 2 source height. a write restarts
//   the image and keeps the line buffer. write only while idle.
// pipeline and throughput:
//   the first copy of a request passes the job stage and then the output
//   register. a new request is taken every cycle while each yields at most
//   one copy and the output is not stalled; a pixel with n copies holds the
//   output until all n copies have left. the line buffer read port delivers
//   replay pixels in the cycle after the request, aligned by the job stage.
// reset: position and counters clear, registers take their defaults, the
//   line buffer is left as is. stalling the output holds the payload and
//   backs up into in_stall_o once the job stage is full.
module nearest_neighbor_image_scaler_top #(
  parameter int unsigned MAX_WIDTH       = 2048,
  parameter int unsigned MAX_HEIGHT      = 2048,
  parameter int unsigned SCALE_FRAC_BITS = 8,
  parameter int unsigned MAX_COPIES      = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nns_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nns_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [nns_pkg::PIX_W-1:0]         blue_in_i,
  input  logic [nns_pkg::PIX_W-1:0]         green_in_i,
  input  logic [nns_pkg::PIX_W-1:0]         red_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nns_pkg::PIX_W-1:0]         blue_out_o,
  output logic [nns_pkg::PIX_W-1:0]         green_out_o,
  output logic [nns_pkg::PIX_W-1:0]         red_out_o,
  output logic                              end_of_row_o,
  output logic [nns_pkg::REPL_W-1:0]        replays_left_o,
  output logic                              end_of_image_o
);
  import nns_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic          accept;
  logic          job_valid;
  job_t          job;
  pixel_t        pix_in;
  pixel_t        rd_data;
  pixel_t        pix_out;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  assign pix_in.blue  = blue_in_i;
  assign pix_in.green = green_in_i;
  assign pix_in.red   = red_in_i;

  nns_ctrl #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .MAX_COPIES     (MAX_COPIES),
    .AW             (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .mode_i     (mode_i),
    .pix_i      (pix_in),
    .job_valid_o(job_valid),
    .job_o      (job),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  nns_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(pix_in),
    .rd_en_i  (job_valid && job.use_mem),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  nns_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .rd_data_i     (rd_data),
    .stall_o       (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pix_o         (pix_out),
    .end_of_row_o  (end_of_row_o),
    .replays_left_o(replays_left_o),
    .end_of_image_o(end_of_image_o)
  );

  assign blue_out_o  = pix_out.blue;
  assign green_out_o = pix_out.green;
  assign red_out_o   = pix_out.red;

  // assertions
`include "assert_macros.svh"

  // the last pixel of the image always closes a row
  `ASSERT_DEF(a_eoi_closes_row, out_valid_o && end_of_image_o |-> end_of_row_o)
  // input backs up only behind a pending output
  `ASSERT_DEF(a_stall_needs_output, in_stall_o |-> out_valid_o)
  // a request causing output while the output is idle reaches the port through the job stage and the output register
  `ASSERT_DEF(a_job_reaches_output, job_valid && !out_valid_o |=> ##1 out_valid_o)

endmodule

// ===== sim/tb_nearest_neighbor_image_scaler_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_image_scaler_top
// self-checking bench for the nearest neighbor image scaler
// ----------------------------------------------------------------------------
// a queue of pixel and replay requests feeds a clocked driver with random
// gaps, and a clocked monitor checks every output pixel against a predictor
// of the scaler that runs on each accepted request. directed images cover
// the corner cases and one long output hold-off, then random images with
// random content and random scale, width and height run with random
// output stalls and a quiet tail.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_image_scaler_top;
  import nns_pkg::*;

  localparam int unsigned MAX_WIDTH       = 2048;
  localparam int unsigned MAX_HEIGHT      = 2048;
  localparam int unsigned SCALE_FRAC_BITS = 8;
  localparam int unsigned MAX_COPIES      = 16;
  // cycles the block may still be busy after the last output pixel
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned RANDOM_REQS     = 130;
  localparam int unsigned LONG_HOLD       = 120;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic              end_of_row;
    logic [REPL_W-1:0] replays_left;
    logic              end_of_image;
  } out_pix_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_SCALE;
  logic [CFG_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i         = MODE_PIXEL;
  logic [PIX_W-1:0]     blue_in_i      = '0;
  logic [PIX_W-1:0]     green_in_i     = '0;
  logic [PIX_W-1:0]     red_in_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [PIX_W-1:0]     blue_out_o;
  logic [PIX_W-1:0]     green_out_o;
  logic [PIX_W-1:0]     red_out_o;
  logic                 end_of_row_o;
  logic [REPL_W-1:0]    replays_left_o;
  logic                 end_of_image_o;

  nearest_neighbor_image_scaler_top #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS),
    .MAX_COPIES     (MAX_COPIES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .blue_in_i     (blue_in_i),
    .green_in_i    (green_in_i),
    .red_in_i      (red_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blue_out_o    (blue_out_o),
    .green_out_o   (green_out_o),
    .red_out_o     (red_out_o),
    .end_of_row_o  (end_of_row_o),
    .replays_left_o(replays_left_o),
    .end_of_image_o(end_of_image_o)
  );

  // requests waiting for the driver, output pixels waiting for the monitor
  pixel_req_t  pending_reqs[$];
  out_pix_t    expected_pixels[$];
  int unsigned mismatch_cnt = 0;
  int unsigned req_cnt      = 0;
  bit          no_idle      = 1'b0;
  bit          hold_req     = 1'b0;

  // predictor copy of the registers and the scaler position
  logic [CFG_W-1:0]       scale_r  = 12'd256;
  logic [CFG_W-1:0]       width_r  = 12'd1;
  logic [CFG_W-1:0]       height_r = 12'd1;
  logic [3*PIX_W-1:0]     row_buf [MAX_WIDTH];
  int unsigned            src_col  = 0;
  int unsigned            src_row  = 0;
  int unsigned            replay_col = 0;
  int unsigned            replays_pending = 0;
  int unsigned            row_edge = 0;

  // clock and reset
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // round half up of idx times the scale factor
  function automatic int unsigned scaled_edge(int unsigned idx);
    longint unsigned prod;
    prod = longint'(idx) * longint'(scale_r) + (64'd1 << (SCALE_FRAC_BITS - 1));
    return int'(prod >> SCALE_FRAC_BITS);
  endfunction

  function automatic int unsigned clamp_copies(longint unsigned n);
    return (n > MAX_COPIES) ? MAX_COPIES : int'(n);
  endfunction

  function automatic int unsigned column_copies(int unsigned col);
    return clamp_copies(scaled_edge(col + 1) - scaled_edge(col));
  endfunction

  function automatic int unsigned eff_width();
    if (width_r == 0) return 1;
    if (width_r > MAX_WIDTH) return MAX_WIDTH;
    return width_r;
  endfunction

  function automatic int unsigned eff_height();
    if (height_r == 0) return 1;
    if (height_r > MAX_HEIGHT) return MAX_HEIGHT;
    return height_r;
  endfunction

  // n copies of one pixel, flags on the last copy only
  task automatic emit_copies(logic [3*PIX_W-1:0] pix, int unsigned n, bit row_end,
                             int unsigned replays, bit image_end);
    out_pix_t op;
    for (int unsigned k = 0; k < n; k++) begin
      op.blue         = pix[PIX_W-1:0];
      op.green        = pix[2*PIX_W-1:PIX_W];
      op.red          = pix[3*PIX_W-1:2*PIX_W];
      op.end_of_row   = row_end && (k + 1 == n);
      op.replays_left = replays[REPL_W-1:0];
      op.end_of_image = image_end && (k + 1 == n);
      expected_pixels.push_back(op);
    end
  endtask

  // output pixels caused by one accepted request
  task automatic scale_request(pixel_req_t rq);
    int unsigned        w;
    int unsigned        h;
    int unsigned        next_edge;
    int unsigned        rows;
    bit                 row_end;
    bit                 image_end;
    logic [3*PIX_W-1:0] pix;
    w = eff_width();
    h = eff_height();
    if (rq.mode == MODE_PIXEL) begin
      pix = {rq.red, rq.green, rq.blue};
      // past the last source row a new image begins
      if (src_row >= h) begin
        src_row  = 0;
        src_col  = 0;
        row_edge = 0;
      end
      if (src_col >= w) src_col = 0;
      row_buf[src_col] = pix;
      next_edge = scaled_edge(src_row + 1) & 32'hFFFF;
      rows      = clamp_copies((next_edge - row_edge) & 32'hFFFF);
      row_end   = (src_col == w - 1);
      if (rows > 0) begin
        image_end = row_end && (src_row == h - 1) && (rows == 1);
        emit_copies(pix, column_copies(src_col), row_end, rows - 1, image_end);
      end
      // a new pixel drops any replays still pending
      replays_pending = 0;
      replay_col      = 0;
      if (row_end) begin
        replays_pending = (rows > 0) ? rows - 1 : 0;
        src_col         = 0;
        row_edge        = next_edge;
        src_row++;
      end else begin
        src_col++;
      end
    end else if (replays_pending != 0 && replay_col < w) begin
      row_end   = (replay_col == w - 1);
      image_end = row_end && (replays_pending == 1) && (src_row >= h);
      emit_copies(row_buf[replay_col], column_copies(replay_col), row_end,
                  replays_pending - 1, image_end);
      if (row_end) begin
        replays_pending--;
        replay_col = 0;
      end else begin
        replay_col++;
      end
    end else if (replays_pending != 0) begin
      replay_col      = 0;
      replays_pending = 0;
    end
  endtask

  // driver: one request per handshake, random gaps between requests
  pixel_req_t  cur_req;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) scale_request(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0 && !no_idle && $urandom_range(0, 99) < 15) begin
          gap_left = $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= cur_req.mode;
          blue_in_i  <= cur_req.blue;
          green_in_i <= cur_req.green;
          red_in_i   <= cur_req.red;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall: random bursts, plus one long hold-off on request
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // monitor: compare each output pixel with the oldest expectation
  out_pix_t exp_pix;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("output pixel with nothing expected: b %0d g %0d r %0d",
               blue_out_o, green_out_o, red_out_o);
        mismatch_cnt++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        check_field("blue_out", exp_pix.blue, blue_out_o);
        check_field("green_out", exp_pix.green, green_out_o);
        check_field("red_out", exp_pix.red, red_out_o);
        check_field("end_of_row", exp_pix.end_of_row, end_of_row_o);
        check_field("replays_left", exp_pix.replays_left, replays_left_o);
        check_field("end_of_image", exp_pix.end_of_image, end_of_image_o);
      end
    end
  end

  function automatic bit busy();
    return pending_reqs.size() != 0 || in_valid_i || expected_pixels.size() != 0;
  endfunction

  // wait for the block to drain before touching the registers,
  // sampled on the falling edge once the driver has settled
  task automatic wait_idle();
    while (busy()) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, mirrored in the predictor; restarts the image
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SCALE:  scale_r  = val;
      CFG_WIDTH:  width_r  = val;
      CFG_HEIGHT: height_r = val;
      default: ;
    endcase
    src_col         = 0;
    src_row         = 0;
    replay_col      = 0;
    replays_pending = 0;
    row_edge        = 0;
  endtask

  task automatic write_config(logic [CFG_W-1:0] scale, logic [CFG_W-1:0] width,
                              logic [CFG_W-1:0] height);
    wait_idle();
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_HEIGHT, height);
    @(negedge clk_i);
  endtask

  // broken sequences drop requests and slip in random ones
  task automatic queue_req(logic mode, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                           logic [PIX_W-1:0] r, bit broken);
    pixel_req_t rq;
    pixel_req_t noise;
    rq.mode  = mode;
    rq.blue  = b;
    rq.green = g;
    rq.red   = r;
    if (broken && $urandom_range(0, 9) == 0) return;
    pending_reqs.push_back(rq);
    req_cnt++;
    if (broken && $urandom_range(0, 9) == 0) begin
      noise.mode  = 1'($urandom_range(0, 1));
      noise.blue  = PIX_W'($urandom_range(0, 255));
      noise.green = PIX_W'($urandom_range(0, 255));
      noise.red   = PIX_W'($urandom_range(0, 255));
      pending_reqs.push_back(noise);
      req_cnt++;
    end
  endtask

  // one image: each row of pixels followed by the replays its rows need
  task automatic queue_image(bit broken);
    int unsigned w;
    int unsigned h;
    int unsigned rows;
    w = eff_width();
    h = eff_height();
    for (int unsigned row = 0; row < h; row++) begin
      rows = clamp_copies(scaled_edge(row + 1) - scaled_edge(row));
      for (int unsigned col = 0; col < w; col++) begin
        queue_req(MODE_PIXEL, PIX_W'($urandom_range(0, 255)),
                  PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                  broken);
      end
      for (int unsigned k = 1; k < rows; k++) begin
        for (int unsigned col = 0; col < w; col++) begin
          queue_req(MODE_REPLAY, PIX_W'($urandom_range(0, 255)),
                    PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                    broken);
        end
      end
    end
  endtask

  // stimulus
  initial begin
    int unsigned      rand_goal;
    int unsigned      pick;
    bit               big;
    bit               broken;
    logic [CFG_W-1:0] scale;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;

    wait (rst_ni);
    wait_idle();
    @(negedge clk_i);

    // reset defaults: unity 1x1 images, new image on each pixel, idle replay
    queue_req(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_req(MODE_REPLAY, 8'h12, 8'h34, 8'h56, 1'b0);

    // largest factor: saturated copies, then a pixel cancels pending replays
    write_config(12'd4095, 12'd2, 12'd2);
    queue_req(MODE_PIXEL, 8'hA5, 8'h5A, 8'h0F, 1'b0);
    queue_req(MODE_PIXEL, 8'h5A, 8'hA5, 8'hF0, 1'b0);
    queue_req(MODE_REPLAY, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_req(MODE_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0);

    // double size: end of image on a replayed row
    write_config(12'd512, 12'd2, 12'd1);
    queue_req(MODE_PIXEL, 8'h01, 8'h80, 8'h7F, 1'b0);
    queue_req(MODE_PIXEL, 8'hFE, 8'h7F, 8'h80, 1'b0);
    queue_req(MODE_REPLAY, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_req(MODE_REPLAY, 8'hFF, 8'hFF, 8'hFF, 1'b0);

    // zero factor: nothing comes out
    write_config(12'd0, 12'd3, 12'd1);
    queue_req(MODE_PIXEL, 8'h11, 8'h22, 8'h33, 1'b0);
    queue_req(MODE_PIXEL, 8'h44, 8'h55, 8'h66, 1'b0);
    queue_req(MODE_PIXEL, 8'h77, 8'h88, 8'h99, 1'b0);
    queue_req(MODE_REPLAY, 8'h00, 8'h00, 8'h00, 1'b0);

    // half size: last column and second row yield no copies
    write_config(12'd128, 12'd2, 12'd2);
    queue_req(MODE_PIXEL, 8'hC3, 8'h3C, 8'h99, 1'b0);
    queue_req(MODE_PIXEL, 8'h3C, 8'hC3, 8'h66, 1'b0);
    queue_req(MODE_PIXEL, 8'h0F, 8'hF0, 8'hAA, 1'b0);
    queue_req(MODE_PIXEL, 8'hF0, 8'h0F, 8'h55, 1'b0);

    // zero width and height count as one
    write_config(12'd384, 12'd0, 12'd0);
    queue_req(MODE_PIXEL, 8'hDE, 8'hAD, 8'hBE, 1'b0);
    queue_req(MODE_REPLAY, 8'h00, 8'h00, 8'h00, 1'b0);

    // width and height above the limits saturate
    write_config(12'd256, 12'd4095, 12'd4095);
    queue_req(MODE_PIXEL, 8'h01, 8'h02, 8'h03, 1'b0);
    queue_req(MODE_PIXEL, 8'h04, 8'h05, 8'h06, 1'b0);
    queue_req(MODE_PIXEL, 8'h07, 8'h08, 8'h09, 1'b0);

    // long output hold-off while requests keep coming
    write_config(12'd1024, 12'd4, 12'd2);
    hold_req = 1'b1;
    queue_image(1'b0);

    // random images, mostly well formed
    rand_goal = req_cnt + RANDOM_REQS;
    while (req_cnt < rand_goal) begin
      pick = $urandom_range(0, 9);
      big  = (pick == 0);
      if (big) scale = CFG_W'($urandom_range(2049, 4095));
      else if (pick == 1) scale = CFG_W'($urandom_range(0, 127));
      else scale = CFG_W'($urandom_range(128, 1024));
      width  = ($urandom_range(0, 19) == 0) ? '0 : CFG_W'($urandom_range(1, big ? 2 : 6));
      height = ($urandom_range(0, 19) == 0) ? '0 : CFG_W'($urandom_range(1, big ? 2 : 4));
      write_config(scale, width, height);
      // quiet tail
      if (req_cnt + 50 >= rand_goal) no_idle = 1'b1;
      broken = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 2)) queue_image(broken);
    end

    for (int unsigned i = 0; i < 100000 && busy(); i++) @(negedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected output pixels never arrived", expected_pixels.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
